[design/ctu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctu_pkg
// shared types, constants and helpers of the cascading four timer unit
// ----------------------------------------------------------------------------
package ctu_pkg;

    localparam int NUM_TIMERS = 4;
    localparam int MAX_TICKS  = 255;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 2;
    localparam int VAL_W   = 16;
    localparam int PRE_W   = 2;
    localparam int TICK_W  = 8;
    localparam int CNT_W   = 18;
    localparam int ACC_W   = 11;
    localparam int SUM_W   = 12;
    localparam int N_W     = 17;
    localparam int OVF_W   = 8;
    localparam int IRQ_W   = 4;
    localparam int IRQ_CNT = (NUM_TIMERS < IRQ_W) ? NUM_TIMERS : IRQ_W;

    // restoring division over the 16 low bits of an overflowed count
    localparam int DIV_STEPS = VAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CMD_W-1:0] CMD_ELAPSE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELOAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CTRL   = 2'd2;

    localparam logic [PRE_W-1:0] PRE_DIV1    = 2'd0;
    localparam logic [PRE_W-1:0] PRE_DIV64   = 2'd1;
    localparam logic [PRE_W-1:0] PRE_DIV256  = 2'd2;
    localparam logic [PRE_W-1:0] PRE_DIV1024 = 2'd3;

    localparam logic [N_W-1:0]   WRAP_VAL   = 17'h10000;
    localparam logic [CNT_W-1:0] CNT_RESET  = '1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  timer_index;
        logic [VAL_W-1:0]  reload_value;
        logic [PRE_W-1:0]  ctrl_prescaler;
        logic              ctrl_cascade;
        logic              ctrl_irq_enable;
        logic              ctrl_start;
        logic [TICK_W-1:0] ticks;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [IRQ_W-1:0] irq_bits;
        logic [OVF_W-1:0] dma_overflows_t0;
        logic [OVF_W-1:0] dma_overflows_t1;
    } out_item_t;

    // token walking down the row of timers during a span
    typedef struct packed {
        logic              valid;
        logic              bump;
        logic [N_W-1:0]    n;
        logic [TICK_W-1:0] ticks;
    } token_t;

    // register write to one timer
    typedef struct packed {
        logic             reload_we;
        logic             ctrl_we;
        logic [VAL_W-1:0] reload;
        logic [PRE_W-1:0] prescaler;
        logic             cascade_en;
        logic             irq_enable;
        logic             start;
    } wr_t;

    // per-timer outcome of the last span
    typedef struct packed {
        logic             irq_hit;
        logic [OVF_W-1:0] ovf;
    } cell_stat_t;

    function automatic logic [OVF_W-1:0] sat8(input logic [N_W-1:0] n);
        logic [OVF_W-1:0] r;
        r = (n > N_W'(255)) ? '1 : n[OVF_W-1:0];
        return r;
    endfunction

endpackage

[design/ctu_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctu_if
// valid/ready channels of the cascading four timer unit
// ----------------------------------------------------------------------------
interface ctu_in_if
    import ctu_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ctu_out_if
    import ctu_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/ctu_timer_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctu_timer_cell
// one 16-bit reload timer with prescaler, cascade input and serial divider
// ----------------------------------------------------------------------------
module ctu_timer_cell
    import ctu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             chain_head,
    input  wr_t              wr,
    input  token_t           tok_in,
    output token_t           tok_out,
    output logic [VAL_W-1:0] readback,
    output cell_stat_t       stat
);

    localparam logic [1:0] S_WAIT = 2'd0;
    localparam logic [1:0] S_ADV  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [VAL_W-1:0]  reload_reg, reload_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [PRE_W-1:0]  sel_reg, sel_next;
    logic              running_reg, running_next;
    logic              start_pend_reg, start_pend_next;
    logic              stop_pend_reg, stop_pend_next;
    logic              irq_en_reg, irq_en_next;
    logic              cascade_reg, cascade_next;
    logic [VAL_W-1:0]  readback_reg, readback_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [VAL_W-1:0]  rem_reg, rem_next;
    logic [VAL_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    token_t            tok_reg, tok_next;
    cell_stat_t        stat_reg, stat_next;

    logic              counts_casc;
    logic [SUM_W-1:0]  acc_sum;
    logic [SUM_W-1:0]  inc;
    logic [ACC_W-1:0]  acc_adv;
    logic [CNT_W-1:0]  c_adv;
    logic              wrap_hit;
    logic [N_W-1:0]    divisor;
    logic [N_W-1:0]    trial;
    logic              trial_ge;
    logic [N_W-1:0]    n_ovf;

    assign counts_casc = cascade_reg && !chain_head;
    assign divisor     = WRAP_VAL - N_W'(reload_reg);
    assign acc_sum     = SUM_W'(acc_reg) + SUM_W'(ticks_reg);

    // prescaler: whole periods go to the count, the rest stays in the accumulator
    always_comb
    begin
        unique case (sel_reg)
            PRE_DIV1:
            begin
                inc     = SUM_W'(ticks_reg);
                acc_adv = acc_reg;
            end
            PRE_DIV64:
            begin
                inc     = acc_sum >> 6;
                acc_adv = ACC_W'(acc_sum[5:0]);
            end
            PRE_DIV256:
            begin
                inc     = acc_sum >> 8;
                acc_adv = ACC_W'(acc_sum[7:0]);
            end
            PRE_DIV1024:
            begin
                inc     = acc_sum >> 10;
                acc_adv = ACC_W'(acc_sum[9:0]);
            end
            default:
            begin
                inc     = '0;
                acc_adv = acc_reg;
            end
        endcase
    end

    assign c_adv    = counts_casc ? count_reg : count_reg + CNT_W'(inc);
    assign wrap_hit = !c_adv[CNT_W-1] && c_adv[VAL_W];

    // one restoring division step per cycle
    assign trial    = {rem_reg, quo_reg[VAL_W-1]};
    assign trial_ge = trial >= divisor;
    assign n_ovf    = N_W'(quo_reg) + N_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        reload_next     = reload_reg;
        acc_next        = acc_reg;
        sel_next        = sel_reg;
        running_next    = running_reg;
        start_pend_next = start_pend_reg;
        stop_pend_next  = stop_pend_reg;
        irq_en_next     = irq_en_reg;
        cascade_next    = cascade_reg;
        readback_next   = readback_reg;
        ticks_next      = ticks_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        tok_next        = tok_reg;
        tok_next.valid  = 1'b0;
        stat_next       = stat_reg;

        if (wr.reload_we)
        begin
            reload_next = wr.reload;
        end
        if (wr.ctrl_we)
        begin
            if (wr.start && !running_reg)
            begin
                start_pend_next = 1'b1;
            end
            else if (running_reg && !wr.start)
            begin
                stop_pend_next = 1'b1;
            end
            running_next = wr.start;
            if (wr.start)
            begin
                irq_en_next  = wr.irq_enable;
                cascade_next = wr.cascade_en;
                sel_next     = wr.prescaler;
            end
        end

        unique case (state_reg)
            S_WAIT:
            begin
                if (tok_in.valid)
                begin
                    ticks_next = tok_in.ticks;
                    stat_next  = '0;
                    // overflows of the timer below land before this timer runs
                    if (tok_in.bump && cascade_reg)
                    begin
                        count_next    = count_reg + CNT_W'(tok_in.n);
                        readback_next = count_next[VAL_W-1:0];
                    end
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                tok_next.bump  = 1'b0;
                tok_next.n     = '0;
                tok_next.ticks = ticks_reg;
                if (start_pend_reg)
                begin
                    start_pend_next = 1'b0;
                    count_next      = CNT_W'(reload_reg);
                    readback_next   = reload_reg;
                    tok_next.valid  = 1'b1;
                    state_next      = S_WAIT;
                end
                else if (running_reg || stop_pend_reg)
                begin
                    stop_pend_next = 1'b0;
                    if (!counts_casc)
                    begin
                        acc_next = acc_adv;
                    end
                    if (wrap_hit)
                    begin
                        rem_next   = '0;
                        quo_next   = c_adv[VAL_W-1:0];
                        step_next  = STEP_W'(DIV_STEPS - 1);
                        state_next = S_DIV;
                    end
                    else
                    begin
                        count_next = c_adv;
                        if (!counts_casc)
                        begin
                            readback_next = c_adv[VAL_W-1:0];
                        end
                        tok_next.valid = 1'b1;
                        state_next     = S_WAIT;
                    end
                end
                else
                begin
                    tok_next.valid = 1'b1;
                    state_next     = S_WAIT;
                end
            end
            S_DIV:
            begin
                rem_next = trial_ge ? VAL_W'(trial - divisor) : trial[VAL_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], trial_ge};
                if (step_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            S_FIN:
            begin
                // wrapped count is reload plus the remainder of the excess
                count_next = CNT_W'(reload_reg) + CNT_W'(rem_reg);
                if (!counts_casc)
                begin
                    readback_next = count_next[VAL_W-1:0];
                end
                stat_next.ovf     = sat8(n_ovf);
                stat_next.irq_hit = irq_en_reg;
                tok_next.valid    = 1'b1;
                tok_next.bump     = 1'b1;
                tok_next.n        = n_ovf;
                state_next        = S_WAIT;
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_WAIT;
            count_reg      <= CNT_RESET;
            reload_reg     <= '0;
            acc_reg        <= '0;
            sel_reg        <= PRE_DIV1;
            running_reg    <= 1'b0;
            start_pend_reg <= 1'b0;
            stop_pend_reg  <= 1'b0;
            irq_en_reg     <= 1'b0;
            cascade_reg    <= 1'b0;
            readback_reg   <= '0;
            step_reg       <= '0;
            tok_reg        <= '0;
            stat_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            reload_reg     <= reload_next;
            acc_reg        <= acc_next;
            sel_reg        <= sel_next;
            running_reg    <= running_next;
            start_pend_reg <= start_pend_next;
            stop_pend_reg  <= stop_pend_next;
            irq_en_reg     <= irq_en_next;
            cascade_reg    <= cascade_next;
            readback_reg   <= readback_next;
            step_reg       <= step_next;
            tok_reg        <= tok_next;
            stat_reg       <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ticks_reg <= ticks_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign tok_out  = tok_reg;
    assign readback = readback_reg;
    assign stat     = stat_reg;

endmodule

[design/cascading_four_timer_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascading_four_timer_unit_core
// four cascadable 16-bit reload timers with prescalers, one item at a time
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one command per transfer: a span of elapsed cycles, a
//   reload write or a control write, addressed by timer_index
//   out_ch returns one result per item: readback of the addressed timer,
//   irq bits and saturated overflow counts of timers 0 and 1
//   one item is in work at a time; in_ch.ready is high only while idle
//   a write item needs no token walk; it takes effect on the transfer
//   a span walks a token down the row of timers; a timer that overflows runs
//   its 16-step serial divider before the token moves on to the next timer
//   the finished result sits in an output register; a new item is taken
//   while it waits, and a stalled receiver holds only the next result back
//   reset (asynchronous, active low) stops all timers, sets every count to
//   minus one and clears reload values, prescalers and pending edges
// ----------------------------------------------------------------------------
module cascading_four_timer_unit_core
    import ctu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ctu_in_if.sink     in_ch,
    ctu_out_if.source  out_ch
);

    // top level sequencer codes
    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    token_t           start_tok_reg, start_tok_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             in_xfer;
    logic [TICK_W-1:0] ticks_clamped;
    out_item_t        result;

    token_t           chain_tok [NUM_TIMERS+1];
    wr_t              cell_wr   [NUM_TIMERS];
    logic [VAL_W-1:0] cell_rb   [NUM_TIMERS];
    cell_stat_t       cell_stat [NUM_TIMERS];

    assign in_ch.ready = (state_reg == T_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // spans longer than the limit count as the limit
    assign ticks_clamped = (32'(in_ch.data.ticks) > MAX_TICKS) ?
                           TICK_W'(MAX_TICKS) : in_ch.data.ticks;

    // register writes go straight to the addressed timer on transfer
    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            always_comb
            begin
                cell_wr[gi].reload_we  = in_xfer && (in_ch.data.cmd == CMD_RELOAD) &&
                                         (in_ch.data.timer_index == IDX_W'(gi));
                cell_wr[gi].ctrl_we    = in_xfer && (in_ch.data.cmd == CMD_CTRL) &&
                                         (in_ch.data.timer_index == IDX_W'(gi));
                cell_wr[gi].reload     = in_ch.data.reload_value;
                cell_wr[gi].prescaler  = in_ch.data.ctrl_prescaler;
                cell_wr[gi].cascade_en = in_ch.data.ctrl_cascade;
                cell_wr[gi].irq_enable = in_ch.data.ctrl_irq_enable;
                cell_wr[gi].start      = in_ch.data.ctrl_start;
            end

            // timer 0 has nothing below it and always counts cycles
            ctu_timer_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .chain_head ((gi == 0) ? 1'b1 : 1'b0),
                .wr         (cell_wr[gi]),
                .tok_in     (chain_tok[gi]),
                .tok_out    (chain_tok[gi+1]),
                .readback   (cell_rb[gi]),
                .stat       (cell_stat[gi])
            );
        end
    endgenerate

    assign chain_tok[0] = start_tok_reg;

    // result assembly once the token has left the last timer
    always_comb
    begin
        result = '0;
        if (32'(idx_reg) < NUM_TIMERS)
        begin
            result.read_value = cell_rb[idx_reg];
        end
        if (cmd_reg == CMD_ELAPSE)
        begin
            for (int i = 0; i < IRQ_CNT; i++)
            begin
                result.irq_bits[i] = cell_stat[i].irq_hit;
            end
            result.dma_overflows_t0 = cell_stat[0].ovf;
            result.dma_overflows_t1 = cell_stat[1].ovf;
        end
    end

    always_comb
    begin
        state_next           = state_reg;
        cmd_next             = cmd_reg;
        idx_next             = idx_reg;
        start_tok_next       = start_tok_reg;
        start_tok_next.valid = 1'b0;
        out_valid_next       = out_valid_reg;
        out_data_next        = out_data_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next = in_ch.data.cmd;
                    idx_next = in_ch.data.timer_index;
                    if (in_ch.data.cmd == CMD_ELAPSE)
                    begin
                        start_tok_next.valid = 1'b1;
                        start_tok_next.bump  = 1'b0;
                        start_tok_next.n     = '0;
                        start_tok_next.ticks = ticks_clamped;
                        state_next           = T_RUN;
                    end
                    else
                    begin
                        state_next = T_FIN;
                    end
                end
            end
            T_RUN:
            begin
                if (chain_tok[NUM_TIMERS].valid)
                begin
                    state_next = T_FIN;
                end
            end
            T_FIN:
            begin
                // load the output register once it is free or being drained
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            cmd_reg       <= CMD_ELAPSE;
            idx_reg       <= '0;
            start_tok_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            start_tok_reg <= start_tok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

[design/ctu_core_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctu_core_checker
// port level checks of the cascading four timer unit
// ----------------------------------------------------------------------------
module ctu_core_checker
    import ctu_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] pend_reg, pend_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // items taken whose result has not been delivered yet
    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result offered with no item outstanding");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two items outstanding");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("new item taken while one is in work");

endmodule

bind cascading_four_timer_unit_core ctu_core_checker u_ctu_core_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
